// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated by reset
`define VPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, gated by reset
`define VPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/vpa_pkg.sv -----
// shared constants of the partition allocator
package vpa_pkg;

  localparam int FREE_SLOTS = 16;
  localparam int USED_SLOTS = 16;
  localparam int FIW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int UIW = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
  localparam int CW  = ((FIW > UIW) ? FIW : UIW) + 1;
  localparam int FREE_W = 32;
  localparam int META_W = 32 + UIW;

  localparam logic [15:0] RESET_TOTAL    = 16'd1024;
  localparam logic [15:0] RESET_MIN_FRAG = 16'd10;
  localparam logic [16:0] TOTAL_MAX      = 17'h1FFFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] CFG_TOTAL   = 2'd0;
  localparam logic [1:0] CFG_POLICY  = 2'd1;
  localparam logic [1:0] CFG_MINFRAG = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_COMPACT   = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE  = 3'd4;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_FSCAN   = 4'd2;
  localparam logic [3:0] S_ALLOCWR = 4'd3;
  localparam logic [3:0] S_USCAN   = 4'd4;
  localparam logic [3:0] S_FSCAN2  = 4'd5;
  localparam logic [3:0] S_FREEWR  = 4'd6;
  localparam logic [3:0] S_AGE     = 4'd7;
  localparam logic [3:0] S_COMPACT = 4'd8;
  localparam logic [3:0] S_NEWENT  = 4'd9;
  localparam logic [3:0] S_RESP    = 4'd10;

endpackage

// ----- rtl/vpa_ram.sv -----
// generic simple dual-port ram with registered read
module vpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic [AW-1:0]           raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/variable_partition_allocator_unit.sv -----
// partition allocator: first, best or worst fit with coalescing and compaction
// one request at a time, next one taken while the result shows; each table
//   sweep reads its entries through the single read port of its ram
// synchronous active-low reset; an init state after reset writes free entry zero
module variable_partition_allocator_unit
  import vpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_target_owner,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_owner_id,
  output logic [15:0] out_block_start,
  output logic [15:0] out_block_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
`include "assert_macros.svh"

  // control state
  logic [3:0]            state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  pv_r, pv_nxt;          // read data of pidx arrives this cycle
  logic [CW-1:0]         pidx_r, pidx_nxt;
  logic [15:0]           total_size_r, total_size_nxt;
  logic [1:0]            fit_policy_r, fit_policy_nxt;
  logic [15:0]           min_fragment_r, min_fragment_nxt;
  logic [16:0]           free_total_r, free_total_nxt;
  logic [15:0]           owner_cnt_r, owner_cnt_nxt;
  logic [FREE_SLOTS-1:0] fvalid_r, fvalid_nxt;
  logic [USED_SLOTS-1:0] uvalid_r, uvalid_nxt;
  logic [USED_SLOTS-1:0] agehas_r, agehas_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  found_r, found_nxt;
  logic                  left_found_r, left_found_nxt;
  logic                  right_found_r, right_found_nxt;
  logic                  compact_r, compact_nxt;
  logic                  is_free_r, is_free_nxt;

  // working payload
  logic [15:0]   req_r, req_nxt;
  logic [UIW-1:0] u_r, u_nxt;
  logic [FIW-1:0] best_r, best_nxt;
  logic [15:0]   best_base_r, best_base_nxt;
  logic [15:0]   best_len_r, best_len_nxt;
  logic [UIW-1:0] k_r, k_nxt;
  logic [UIW-1:0] age_k_r, age_k_nxt;
  logic [15:0]   len_k_r, len_k_nxt;
  logic [FIW-1:0] left_r, left_nxt;
  logic [15:0]   left_base_r, left_base_nxt;
  logic [15:0]   left_len_r, left_len_nxt;
  logic [FIW-1:0] right_r, right_nxt;
  logic [15:0]   right_len_r, right_len_nxt;
  logic [15:0]   cursor_r, cursor_nxt;
  logic [15:0]   start_r, start_nxt;
  logic [15:0]   grant_r, grant_nxt;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [15:0]   res_owner_r, res_owner_nxt;
  logic [15:0]   res_start_r, res_start_nxt;
  logic [15:0]   res_len_r, res_len_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [15:0]   out_owner_r, out_owner_nxt;
  logic [15:0]   out_start_r, out_start_nxt;
  logic [15:0]   out_len_r, out_len_nxt;
  // per-age record of the used blocks, filled by the age sweep for compaction
  logic [15:0]    agelen_r [USED_SLOTS];
  logic [15:0]    agelen_nxt [USED_SLOTS];
  logic [UIW-1:0] ageidx_r [USED_SLOTS];
  logic [UIW-1:0] ageidx_nxt [USED_SLOTS];

  // ram ports
  logic              free_we;
  logic [FIW-1:0]    free_waddr;
  logic [FREE_W-1:0] free_wdata, free_rdata;
  logic              meta_we;
  logic [UIW-1:0]    meta_waddr;
  logic [META_W-1:0] meta_wdata, meta_rdata;
  logic              ubase_we;
  logic [UIW-1:0]    ubase_waddr;
  logic [15:0]       ubase_wdata, ubase_rdata;

  // free table entries hold {base, length}
  vpa_ram #(.WIDTH(FREE_W), .DEPTH(FREE_SLOTS)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .raddr(cnt_r[FIW-1:0]), .rdata(free_rdata)
  );

  // used table entries hold {owner, length, age}
  vpa_ram #(.WIDTH(META_W), .DEPTH(USED_SLOTS)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(cnt_r[UIW-1:0]), .rdata(meta_rdata)
  );

  // used block base addresses, kept apart so compaction rewrites only the base
  vpa_ram #(.WIDTH(16), .DEPTH(USED_SLOTS)) u_ubase_ram (
    .clk(clk), .we(ubase_we), .waddr(ubase_waddr), .wdata(ubase_wdata),
    .raddr(k_r), .rdata(ubase_rdata)
  );

  // lowest clear bit of the used valid vector
  function automatic logic [UIW:0] first_free_used(input logic [USED_SLOTS-1:0] v);
    logic [UIW:0] r;
    r = '0;
    for (int i = USED_SLOTS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        r = {1'b1, UIW'(i)};
      end
    end
    return r;
  endfunction

  // lowest clear bit of the free valid vector
  function automatic logic [FIW:0] first_free_slot(input logic [FREE_SLOTS-1:0] v);
    logic [FIW:0] r;
    r = '0;
    for (int i = FREE_SLOTS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        r = {1'b1, FIW'(i)};
      end
    end
    return r;
  endfunction

  // read data split
  logic [15:0]    fb, fl;
  logic [15:0]    m_owner, m_len;
  logic [UIW-1:0] m_age;
  assign fb      = free_rdata[31:16];
  assign fl      = free_rdata[15:0];
  assign m_owner = meta_rdata[META_W-1 -: 16];
  assign m_len   = meta_rdata[UIW +: 16];
  assign m_age   = meta_rdata[UIW-1:0];

  // sweep sequencing: one read issued per cycle, processed when its registered data returns
  logic [CW-1:0] limit;
  logic          issue, sweep_done;
  logic [FIW-1:0] pf;
  logic [UIW-1:0] pu;
  assign pf = pidx_r[FIW-1:0];
  assign pu = pidx_r[UIW-1:0];
  always_comb begin
    limit = CW'(USED_SLOTS);
    if (state_r == S_FSCAN || state_r == S_FSCAN2) begin
      limit = CW'(FREE_SLOTS);
    end
  end
  assign issue      = (cnt_r < limit);
  assign sweep_done = !issue && !pv_r;

  // fit policy comparison of the candidate against the best so far
  logic lower, better;
  assign lower = fb < best_base_r;
  always_comb begin
    case (fit_policy_r)
      POL_BEST:  better = (fl < best_len_r) || ((fl == best_len_r) && lower);
      POL_WORST: better = (fl > best_len_r) || ((fl == best_len_r) && lower);
      default:   better = lower;
    endcase
  end

  // free path: neighbour addresses of the returned block
  logic [16:0] end_k, fsum;
  assign end_k = {1'b0, ubase_rdata} + {1'b0, len_k_r};
  assign fsum  = {1'b0, fb} + {1'b0, fl};

  logic [UIW:0] ufree;
  logic [FIW:0] fslot;
  assign ufree = first_free_used(uvalid_r);
  assign fslot = first_free_slot(fvalid_r);

  // allocate arithmetic
  logic [15:0] diff;
  logic [16:0] need17, remain17, grant17;
  logic [17:0] fsum_tot;
  assign diff     = best_len_r - req_r;
  assign need17   = {1'b0, req_r} + {1'b0, min_fragment_r};
  assign fsum_tot = {1'b0, free_total_r} + {2'b0, len_k_r};

  logic [15:0] cur_sub;
  assign cur_sub = cursor_r - agelen_r[cnt_r[UIW-1:0]];

  // register writes are taken only while no request is being worked on
  logic in_fire, out_fire, cfg_fire;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_fire  = out_valid_r && out_ready;

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    pv_nxt           = 1'b0;
    pidx_nxt         = pidx_r;
    total_size_nxt   = total_size_r;
    fit_policy_nxt   = fit_policy_r;
    min_fragment_nxt = min_fragment_r;
    free_total_nxt   = free_total_r;
    owner_cnt_nxt    = owner_cnt_r;
    fvalid_nxt       = fvalid_r;
    uvalid_nxt       = uvalid_r;
    agehas_nxt       = agehas_r;
    out_valid_nxt    = out_valid_r;
    found_nxt        = found_r;
    left_found_nxt   = left_found_r;
    right_found_nxt  = right_found_r;
    compact_nxt      = compact_r;
    is_free_nxt      = is_free_r;
    req_nxt          = req_r;
    u_nxt            = u_r;
    best_nxt         = best_r;
    best_base_nxt    = best_base_r;
    best_len_nxt     = best_len_r;
    k_nxt            = k_r;
    age_k_nxt        = age_k_r;
    len_k_nxt        = len_k_r;
    left_nxt         = left_r;
    left_base_nxt    = left_base_r;
    left_len_nxt     = left_len_r;
    right_nxt        = right_r;
    right_len_nxt    = right_len_r;
    cursor_nxt       = cursor_r;
    start_nxt        = start_r;
    grant_nxt        = grant_r;
    res_status_nxt   = res_status_r;
    res_owner_nxt    = res_owner_r;
    res_start_nxt    = res_start_r;
    res_len_nxt      = res_len_r;
    out_status_nxt   = out_status_r;
    out_owner_nxt    = out_owner_r;
    out_start_nxt    = out_start_r;
    out_len_nxt      = out_len_r;
    agelen_nxt       = agelen_r;
    ageidx_nxt       = ageidx_r;
    remain17         = '0;
    grant17          = '0;
    free_we          = 1'b0;
    free_waddr       = '0;
    free_wdata       = '0;
    meta_we          = 1'b0;
    meta_waddr       = pu;
    meta_wdata       = meta_rdata;
    ubase_we         = 1'b0;
    ubase_waddr      = ageidx_r[cnt_r[UIW-1:0]];
    ubase_wdata      = cur_sub;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    // scan states share the read pipeline
    if (state_r == S_FSCAN || state_r == S_FSCAN2 || state_r == S_USCAN ||
        state_r == S_AGE) begin
      if (issue) begin
        pv_nxt   = 1'b1;
        pidx_nxt = cnt_r;
        cnt_nxt  = cnt_r + CW'(1);
      end
    end

    unique case (state_r)
      S_INIT: begin
        // load the single reset block into free entry zero
        free_we    = 1'b1;
        free_wdata = {16'd0, total_size_r};
        state_nxt  = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_fire) begin
          unique case (cfg_index)
            CFG_TOTAL: begin
              total_size_nxt = cfg_data;
              free_we        = 1'b1;
              free_wdata     = {16'd0, cfg_data};
              fvalid_nxt     = '0;
              fvalid_nxt[0]  = (cfg_data != 16'd0);
              free_total_nxt = {1'b0, cfg_data};
            end
            CFG_POLICY:  fit_policy_nxt   = cfg_data[1:0];
            CFG_MINFRAG: min_fragment_nxt = cfg_data;
            default: ;
          endcase
        end
        if (in_fire) begin
          cnt_nxt         = '0;
          found_nxt       = 1'b0;
          left_found_nxt  = 1'b0;
          right_found_nxt = 1'b0;
          compact_nxt     = 1'b0;
          agehas_nxt      = '0;
          res_start_nxt   = '0;
          res_len_nxt     = '0;
          req_nxt         = in_request_size;
          is_free_nxt     = (in_command == CMD_FREE);
          if (in_command == CMD_FREE) begin
            res_owner_nxt = in_target_owner;
            state_nxt     = S_USCAN;
          end else begin
            owner_cnt_nxt = owner_cnt_r + 16'd1;
            res_owner_nxt = owner_cnt_r + 16'd1;
            u_nxt         = ufree[UIW-1:0];
            if (in_request_size == 16'd0) begin
              res_status_nxt = ST_BAD_SIZE;
              state_nxt      = S_RESP;
            end else if (!ufree[UIW]) begin
              res_status_nxt = ST_NO_SPACE;
              state_nxt      = S_RESP;
            end else begin
              state_nxt = S_FSCAN;
            end
          end
        end
      end
      S_FSCAN: begin
        if (pv_r && fvalid_r[pf] && (fl >= req_r) && (!found_r || better)) begin
          found_nxt     = 1'b1;
          best_nxt      = pf;
          best_base_nxt = fb;
          best_len_nxt  = fl;
        end
        if (sweep_done) begin
          state_nxt = S_ALLOCWR;
        end
      end
      S_ALLOCWR: begin
        cnt_nxt = '0;
        if (found_r) begin
          free_waddr = best_r;
          start_nxt  = best_base_r;
          if (diff >= min_fragment_r) begin
            grant17    = {1'b0, req_r};
            free_we    = 1'b1;
            free_wdata = {best_base_r + req_r, diff};
          end else begin
            grant17            = {1'b0, best_len_r};
            fvalid_nxt[best_r] = 1'b0;
          end
          free_total_nxt = (free_total_r >= grant17) ? free_total_r - grant17 : '0;
          grant_nxt      = grant17[15:0];
          res_status_nxt = ST_OK;
          state_nxt      = S_AGE;
        end else if (free_total_r >= {1'b0, req_r}) begin
          // compaction: at most one free region left, at the top of memory
          if (free_total_r >= need17) begin
            grant17  = {1'b0, req_r};
            remain17 = free_total_r - {1'b0, req_r};
          end else begin
            grant17  = free_total_r;
            remain17 = '0;
          end
          fvalid_nxt = '0;
          if (remain17 != 17'd0) begin
            free_we       = 1'b1;
            free_wdata    = {total_size_r - remain17[15:0], remain17[15:0]};
            fvalid_nxt[0] = (remain17[15:0] != 16'd0);
          end
          free_total_nxt = remain17;
          start_nxt      = total_size_r - remain17[15:0] - grant17[15:0];
          cursor_nxt     = total_size_r - remain17[15:0] - grant17[15:0];
          grant_nxt      = grant17[15:0];
          compact_nxt    = 1'b1;
          res_status_nxt = ST_COMPACT;
          state_nxt      = S_AGE;
        end else begin
          res_status_nxt = ST_NO_SPACE;
          state_nxt      = S_RESP;
        end
      end
      S_USCAN: begin
        if (pv_r && uvalid_r[pu] && (m_owner == res_owner_r) &&
            (!found_r || (m_age < age_k_r))) begin
          found_nxt = 1'b1;
          k_nxt     = pu;
          age_k_nxt = m_age;
          len_k_nxt = m_len;
        end
        if (sweep_done) begin
          cnt_nxt = '0;
          if (!found_r) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_FSCAN2;
          end
        end
      end
      S_FSCAN2: begin
        // ubase_rdata holds the base of the block being returned
        if (pv_r && fvalid_r[pf]) begin
          if ((fsum == {1'b0, ubase_rdata}) && !left_found_r) begin
            left_found_nxt = 1'b1;
            left_nxt       = pf;
            left_base_nxt  = fb;
            left_len_nxt   = fl;
          end else if (({1'b0, fb} == end_k) && !right_found_r) begin
            right_found_nxt = 1'b1;
            right_nxt       = pf;
            right_len_nxt   = fl;
          end
        end
        if (sweep_done) begin
          state_nxt = S_FREEWR;
        end
      end
      S_FREEWR: begin
        cnt_nxt       = '0;
        res_start_nxt = ubase_rdata;
        res_len_nxt   = len_k_r;
        if (left_found_r) begin
          free_we    = 1'b1;
          free_waddr = left_r;
          if (right_found_r) begin
            free_wdata          = {left_base_r, left_len_r + len_k_r + right_len_r};
            fvalid_nxt[right_r] = 1'b0;
          end else begin
            free_wdata = {left_base_r, left_len_r + len_k_r};
          end
        end else if (right_found_r) begin
          free_we    = 1'b1;
          free_waddr = right_r;
          free_wdata = {ubase_rdata, right_len_r + len_k_r};
        end else if (fslot[FIW]) begin
          free_we                   = 1'b1;
          free_waddr                = fslot[FIW-1:0];
          free_wdata                = {ubase_rdata, len_k_r};
          fvalid_nxt[fslot[FIW-1:0]] = (len_k_r != 16'd0);
        end
        if (left_found_r || right_found_r || fslot[FIW]) begin
          uvalid_nxt[k_r] = 1'b0;
          free_total_nxt  = (fsum_tot > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : fsum_tot[16:0];
          res_status_nxt  = ST_OK;
          state_nxt       = S_AGE;
        end else begin
          // no merge and no empty free entry: the block stays allocated
          res_status_nxt = ST_NO_SPACE;
          res_start_nxt  = '0;
          res_len_nxt    = '0;
          state_nxt      = S_RESP;
        end
      end
      S_AGE: begin
        if (pv_r && uvalid_r[pu]) begin
          if (is_free_r) begin
            if (m_age > age_k_r) begin
              meta_we    = 1'b1;
              meta_wdata = {m_owner, m_len, m_age - UIW'(1)};
            end
          end else begin
            meta_we            = 1'b1;
            meta_wdata         = {m_owner, m_len, m_age + UIW'(1)};
            agehas_nxt[m_age]  = 1'b1;
            agelen_nxt[m_age]  = m_len;
            ageidx_nxt[m_age]  = pu;
          end
        end
        if (sweep_done) begin
          cnt_nxt = '0;
          if (is_free_r) begin
            state_nxt = S_RESP;
          end else if (compact_r) begin
            state_nxt = S_COMPACT;
          end else begin
            state_nxt = S_NEWENT;
          end
        end
      end
      S_COMPACT: begin
        // pack older blocks below the new one, youngest first
        if (agehas_r[cnt_r[UIW-1:0]]) begin
          ubase_we   = 1'b1;
          cursor_nxt = cur_sub;
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(USED_SLOTS - 1)) begin
          state_nxt = S_NEWENT;
        end
      end
      S_NEWENT: begin
        meta_we         = 1'b1;
        meta_waddr      = u_r;
        meta_wdata      = {owner_cnt_r, grant_r, UIW'(0)};
        ubase_we        = 1'b1;
        ubase_waddr     = u_r;
        ubase_wdata     = start_r;
        uvalid_nxt[u_r] = 1'b1;
        res_start_nxt   = start_r;
        res_len_nxt     = grant_r;
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_owner_nxt  = res_owner_r;
          out_start_nxt  = res_start_r;
          out_len_nxt    = res_len_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_INIT;
      cnt_r          <= '0;
      pv_r           <= 1'b0;
      total_size_r   <= RESET_TOTAL;
      fit_policy_r   <= POL_FIRST;
      min_fragment_r <= RESET_MIN_FRAG;
      free_total_r   <= {1'b0, RESET_TOTAL};
      owner_cnt_r    <= '0;
      fvalid_r       <= FREE_SLOTS'(1);
      uvalid_r       <= '0;
      agehas_r       <= '0;
      out_valid_r    <= 1'b0;
      found_r        <= 1'b0;
      left_found_r   <= 1'b0;
      right_found_r  <= 1'b0;
      compact_r      <= 1'b0;
      is_free_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      pv_r           <= pv_nxt;
      total_size_r   <= total_size_nxt;
      fit_policy_r   <= fit_policy_nxt;
      min_fragment_r <= min_fragment_nxt;
      free_total_r   <= free_total_nxt;
      owner_cnt_r    <= owner_cnt_nxt;
      fvalid_r       <= fvalid_nxt;
      uvalid_r       <= uvalid_nxt;
      agehas_r       <= agehas_nxt;
      out_valid_r    <= out_valid_nxt;
      found_r        <= found_nxt;
      left_found_r   <= left_found_nxt;
      right_found_r  <= right_found_nxt;
      compact_r      <= compact_nxt;
      is_free_r      <= is_free_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    req_r        <= req_nxt;
    u_r          <= u_nxt;
    best_r       <= best_nxt;
    best_base_r  <= best_base_nxt;
    best_len_r   <= best_len_nxt;
    k_r          <= k_nxt;
    age_k_r      <= age_k_nxt;
    len_k_r      <= len_k_nxt;
    left_r       <= left_nxt;
    left_base_r  <= left_base_nxt;
    left_len_r   <= left_len_nxt;
    right_r      <= right_nxt;
    right_len_r  <= right_len_nxt;
    cursor_r     <= cursor_nxt;
    start_r      <= start_nxt;
    grant_r      <= grant_nxt;
    res_status_r <= res_status_nxt;
    res_owner_r  <= res_owner_nxt;
    res_start_r  <= res_start_nxt;
    res_len_r    <= res_len_nxt;
    out_status_r <= out_status_nxt;
    out_owner_r  <= out_owner_nxt;
    out_start_r  <= out_start_nxt;
    out_len_r    <= out_len_nxt;
    agelen_r     <= agelen_nxt;
    ageidx_r     <= ageidx_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_owner_id     = out_owner_r;
  assign out_block_start  = out_start_r;
  assign out_block_length = out_len_r;

  // an accepted request always leaves idle
  `VPA_ASSERT_NEXT(a_leave_idle, clk, rst_n, in_fire, state_r != S_IDLE)
  // a new used entry is marked valid once written
  `VPA_ASSERT_NEXT(a_newent_valid, clk, rst_n, state_r == S_NEWENT, uvalid_r[u_r])
  // compaction runs only for allocates that report it
  `VPA_ASSERT_NOW(a_compact_status, clk, rst_n, state_r == S_COMPACT,
                  (res_status_r == ST_COMPACT) && !is_free_r)
  // a result leaving the response state is shown on the port
  `VPA_ASSERT_NEXT(a_resp_out, clk, rst_n,
                   (state_r == S_RESP) && (!out_valid_r || out_ready), out_valid_r)
endmodule
